/* rtl/core/rrf_pkg.sv */
package rrf_pkg;

	localparam int MAX_COLUMNS = 512;
	localparam int MAX_ROWS    = 512;

	localparam int COL_W        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ADDR_W       = COL_W + ROW_W;
	localparam int CANVAS_DEPTH = 1 << ADDR_W;

	localparam int COORD_W  = 24;
	localparam int ONE_UNIT = 256;

	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_SYMBOL = 2'd2;

	localparam logic [9:0] RESET_CANVAS_WIDTH      = 10'd1;
	localparam logic [9:0] RESET_CANVAS_HEIGHT     = 10'd1;
	localparam logic [7:0] RESET_BACKGROUND_SYMBOL = 8'd32;

	localparam logic [7:0] SHAPE_OUTLINE = 8'd114;
	localparam logic [7:0] SHAPE_FILLED  = 8'd82;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_DRAW  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;

	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 8;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_DRAW  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [1:0]                status;
		logic                      outline;
		logic [7:0]                symbol;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] left_in;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] right_in;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] top_in;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] bottom_in;
		logic [8:0]                read_x;
		logic [8:0]                read_y;
	} cmd_t;

endpackage

/* rtl/core/rrf_ram.sv */
module rrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/rrf_front.sv */
module rrf_front
	import rrf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// shape_type, left, top, rect_width, rect_height, fill_symbol, read_x, read_y, zero pad
	input  logic [IN_DATA_W-1:0] s_tdata,
	// action
	input  logic [1:0]           s_tuser,
	input  logic                 q_full,
	output logic                 push,
	output cmd_t                 push_cmd
);

	logic              err_q;
	logic [7:0]        shape_type;
	logic signed [19:0] left, top, rect_width, rect_height;
	logic [7:0]        fill_symbol;
	logic [8:0]        read_x, read_y;
	logic              shape_ok, draw_ok;
	logic signed [COORD_W-1:0] l_ext, t_ext, r_ext, b_ext;

	assign shape_type  = s_tdata[7:0];
	assign left        = s_tdata[27:8];
	assign top         = s_tdata[47:28];
	assign rect_width  = s_tdata[67:48];
	assign rect_height = s_tdata[87:68];
	assign fill_symbol = s_tdata[95:88];
	assign read_x      = s_tdata[104:96];
	assign read_y      = s_tdata[113:105];

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	assign shape_ok = (shape_type == SHAPE_OUTLINE) || (shape_type == SHAPE_FILLED);
	assign draw_ok  = shape_ok && (rect_width > 20'sd0) && (rect_height > 20'sd0);

	assign l_ext = COORD_W'(left);
	assign t_ext = COORD_W'(top);
	assign r_ext = l_ext + COORD_W'(rect_width);
	assign b_ext = t_ext + COORD_W'(rect_height);

	always_comb begin
		push_cmd           = '0;
		push_cmd.outline   = (shape_type == SHAPE_OUTLINE);
		push_cmd.symbol    = fill_symbol;
		push_cmd.left      = l_ext;
		push_cmd.left_in   = l_ext + COORD_W'(ONE_UNIT);
		push_cmd.right     = r_ext;
		push_cmd.right_in  = r_ext - COORD_W'(ONE_UNIT);
		push_cmd.top       = t_ext;
		push_cmd.top_in    = t_ext + COORD_W'(ONE_UNIT);
		push_cmd.bottom    = b_ext;
		push_cmd.bottom_in = b_ext - COORD_W'(ONE_UNIT);
		push_cmd.read_x    = read_x;
		push_cmd.read_y    = read_y;
		push_cmd.op        = OP_NONE;
		push_cmd.status    = STAT_OK;
		unique case (s_tuser)
			ACT_CLEAR: begin
				push_cmd.op = OP_CLEAR;
			end
			ACT_DRAW: begin
				if (err_q) begin
					push_cmd.status = STAT_IGNORED;
				end else if (!draw_ok) begin
					push_cmd.status = STAT_INVALID;
				end else begin
					push_cmd.op = OP_DRAW;
				end
			end
			ACT_READ: begin
				push_cmd.op = OP_READ;
			end
			default: begin
				push_cmd.op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (push) begin
			if (s_tuser == ACT_CLEAR) begin
				err_q <= 1'b0;
			end else if (s_tuser == ACT_DRAW && !draw_ok) begin
				err_q <= 1'b1;
			end
		end
	end

endmodule

/* rtl/core/rrf_fifo.sv */
module rrf_fifo
	import rrf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/rrf_back.sv */
module rrf_back
	import rrf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  cmd_t                  q_cmd,
	output logic                  q_pop,
	input  logic [9:0]            canvas_width,
	input  logic [9:0]            canvas_height,
	input  logic [7:0]            background_symbol,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_value
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [1:0]            m_tuser
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_DONE  = 3'b100
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [COL_W-1:0]   x_q, last_col;
	logic [ROW_W-1:0]   y_q, last_row;
	logic               pix_sel_q;
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]         m_tuser_q;
	logic signed [COORD_W-1:0] px, py;
	logic               in_rect, on_border, hit;
	logic               in_range;
	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [7:0]         ram_wdata, ram_rdata;
	logic               out_load;

	always_comb begin
		if (canvas_width == '0) begin
			last_col = '0;
		end else if (int'(canvas_width) > MAX_COLUMNS) begin
			last_col = COL_W'(MAX_COLUMNS - 1);
		end else begin
			last_col = COL_W'(canvas_width - 10'd1);
		end
		if (canvas_height == '0) begin
			last_row = '0;
		end else if (int'(canvas_height) > MAX_ROWS) begin
			last_row = ROW_W'(MAX_ROWS - 1);
		end else begin
			last_row = ROW_W'(canvas_height - 10'd1);
		end
	end

	assign px = COORD_W'($signed({1'b0, x_q, 8'h00}));
	assign py = COORD_W'($signed({1'b0, y_q, 8'h00}));

	assign in_rect   = (px >= cmd_q.left) && (px <= cmd_q.right) &&
	                   (py >= cmd_q.top) && (py <= cmd_q.bottom);
	assign on_border = (px < cmd_q.left_in) || (px > cmd_q.right_in) ||
	                   (py < cmd_q.top_in) || (py > cmd_q.bottom_in);
	assign hit       = in_rect && (!cmd_q.outline || on_border);

	assign in_range = (int'(q_cmd.read_x) <= int'(last_col)) &&
	                  (int'(q_cmd.read_y) <= int'(last_row));

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign ram_re    = q_pop && (q_cmd.op == OP_READ);
	assign ram_raddr = {ROW_W'(q_cmd.read_y), COL_W'(q_cmd.read_x)};
	assign ram_we    = (state_q == ST_SWEEP) && ((cmd_q.op == OP_CLEAR) || hit);
	assign ram_waddr = {y_q, x_q};
	assign ram_wdata = (cmd_q.op == OP_CLEAR) ? background_symbol : cmd_q.symbol;

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	rrf_ram #(
		.WIDTH(8),
		.DEPTH(CANVAS_DEPTH)
	) u_canvas (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (out_load) begin
			m_tuser_q <= cmd_q.status;
			m_tdata_q <= pix_sel_q ? ram_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			x_q        <= '0;
			y_q        <= '0;
			pix_sel_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						x_q       <= '0;
						y_q       <= '0;
						pix_sel_q <= (q_cmd.op == OP_READ) && in_range;
						if (q_cmd.op == OP_CLEAR || q_cmd.op == OP_DRAW) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SWEEP: begin
					if (x_q == last_col) begin
						x_q <= '0;
						if (y_q == last_row) begin
							state_q <= ST_DONE;
						end else begin
							y_q <= y_q + 1'b1;
						end
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* rtl/core/rectangle_raster_fill_top.sv */
// Rectangle rasterizer on a byte canvas of up to MAX_COLUMNS by MAX_ROWS pixels, held in one
// single-write-port RAM. Commands arrive on the s_ stream (action in s_tuser), are checked
// and turned into bounds by the front end, wait in a two-entry queue, and are carried out by
// a back end that returns one status/pixel transfer per command on the m_ stream. A clear or
// a successful draw sweeps the active area one pixel per cycle; a read, a rejected or
// ignored draw, and an unused action skip the sweep. The canvas powers up undefined and gets
// no clearing pass: issue a clear before the first read. Write the registers only while idle.
module rectangle_raster_fill_top
	import rrf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// shape_type, left, top, rect_width, rect_height, fill_symbol, read_x, read_y, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_value
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [1:0]            m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [9:0] canvas_width_q, canvas_height_q;
	logic [7:0] background_symbol_q;
	logic       push, q_full, q_valid, q_pop;
	cmd_t       push_cmd, q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q      <= RESET_CANVAS_WIDTH;
			canvas_height_q     <= RESET_CANVAS_HEIGHT;
			background_symbol_q <= RESET_BACKGROUND_SYMBOL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CANVAS_WIDTH:      canvas_width_q      <= cfg_data[9:0];
				REG_CANVAS_HEIGHT:     canvas_height_q     <= cfg_data[9:0];
				REG_BACKGROUND_SYMBOL: background_symbol_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	rrf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	rrf_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (q_cmd)
	);

	rrf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_cmd            (q_cmd),
		.q_pop            (q_pop),
		.canvas_width     (canvas_width_q),
		.canvas_height    (canvas_height_q),
		.background_symbol(background_symbol_q),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser)
	);

endmodule
